[hdl/iqss_pkg.sv]
// Shared types and codes for the input-queued switch scheduler.
// Used by iqss_front, iqss_engine, iqss_outq and the top level.
// No dependencies.
package iqss_pkg;

    // Command codes
    localparam logic CMD_ENQUEUE = 1'b0;
    localparam logic CMD_SLOT    = 1'b1;

    // Report status codes
    localparam logic [2:0] STAT_ENQUEUED = 3'd0;
    localparam logic [2:0] STAT_DROPPED  = 3'd1;
    localparam logic [2:0] STAT_EMPTY    = 3'd2;
    localparam logic [2:0] STAT_GRANTED  = 3'd3;
    localparam logic [2:0] STAT_BLOCKED  = 3'd4;

    // Classified command handed from the front end to the engine
    typedef struct packed {
        logic       op;
        logic [3:0] in_port;
        logic [3:0] dest_port;
        logic       in_range;   // both port numbers exist in this switch
    } cmd_t;

    // One report transaction
    typedef struct packed {
        logic [2:0] status;
        logic [3:0] port;
        logic [3:0] out_port;
        logic       last;
    } result_t;

endpackage

[hdl/iqss_front.sv]
// Front end: accepts command transactions, range-checks the port numbers
// and holds them in a two-entry queue for the engine. Depends on iqss_pkg.
module iqss_front
    import iqss_pkg::*;
#(
    parameter int PORTS = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  logic       command,
    input  logic [3:0] in_port,
    input  logic [3:0] dest_port,
    output logic       full,
    output logic       cmd_valid,
    output cmd_t       cmd,
    input  logic       cmd_ready
);

    cmd_t head_reg;
    cmd_t spare_reg;
    logic head_vld_reg;
    logic spare_vld_reg;
    cmd_t in_cmd;
    logic wr;
    logic rd;

    // Classify the incoming transaction
    always_comb
    begin
        in_cmd.op        = command;
        in_cmd.in_port   = in_port;
        in_cmd.dest_port = dest_port;
        in_cmd.in_range  = (32'(in_port) < PORTS) && (32'(dest_port) < PORTS);
    end

    assign full      = spare_vld_reg;
    assign wr        = push && !spare_vld_reg;
    assign rd        = cmd_ready && head_vld_reg;
    assign cmd_valid = head_vld_reg;
    assign cmd       = head_reg;

    // Two-entry queue: head feeds the engine, spare catches one more
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_vld_reg  <= 1'b0;
            spare_vld_reg <= 1'b0;
        end
        else
        begin
            if (rd)
            begin
                if (spare_vld_reg)
                begin
                    head_reg      <= spare_reg;
                    spare_vld_reg <= 1'b0;
                end
                else if (wr)
                begin
                    head_reg <= in_cmd;
                end
                else
                begin
                    head_vld_reg <= 1'b0;
                end
            end
            else if (wr)
            begin
                if (!head_vld_reg)
                begin
                    head_reg     <= in_cmd;
                    head_vld_reg <= 1'b1;
                end
                else
                begin
                    spare_reg     <= in_cmd;
                    spare_vld_reg <= 1'b1;
                end
            end
        end
    end

endmodule

[hdl/iqss_engine.sv]
// Back end: executes enqueue and time-slot commands against the per-port
// queue memories and emits report transactions. Depends on iqss_pkg.
module iqss_engine
    import iqss_pkg::*;
#(
    parameter int PORTS       = 16,
    parameter int QUEUE_DEPTH = 16
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    cmd_valid,
    input  cmd_t    cmd,
    output logic    cmd_ready,
    output logic    res_valid,
    output result_t res,
    input  logic    res_ready
);

    localparam int PIW = $clog2(PORTS);
    localparam int HW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW  = $clog2(QUEUE_DEPTH + 1);
    localparam int SAW = $clog2(PORTS * QUEUE_DEPTH);
    localparam int RPT = (PORTS < 16) ? PORTS : 16;

    localparam logic [PIW:0]   RPT_L  = (PIW + 1)'(RPT);
    localparam logic [PIW-1:0] LAST_P = PIW'(RPT - 1);
    localparam logic [PIW-1:0] MAX_P  = PIW'(PORTS - 1);
    localparam logic [HW-1:0]  MAX_H  = HW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0]  D_C    = CW'(QUEUE_DEPTH);
    localparam logic [CW:0]    D_S    = (CW + 1)'(QUEUE_DEPTH);
    localparam logic [SAW-1:0] QD_A   = SAW'(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ENQ_CHK,
        S_SLOT_RD,
        S_SLOT_CHK,
        S_SLOT_EXEC
    } state_t;

    typedef struct packed {
        logic [HW-1:0] head;
        logic [CW-1:0] count;
    } pstate_t;

    // (a + b) mod QUEUE_DEPTH for a < depth, b <= depth
    function automatic logic [HW-1:0] wrap_add(input logic [HW-1:0] a,
                                               input logic [CW-1:0] b);
        logic [CW:0] s;
        s = (CW + 1)'(a) + (CW + 1)'(b);
        if (s >= D_S)
            s = s - D_S;
        return HW'(s);
    endfunction

    // Base address of one port's queue in the store
    function automatic logic [SAW-1:0] qbase(input logic [PIW-1:0] p);
        return SAW'(SAW'(p) * QD_A);
    endfunction

    state_t         state_reg, state_next;
    cmd_t           cmd_reg, cmd_next;
    logic [PIW-1:0] port_reg, port_next;
    logic [PORTS-1:0] taken_reg, taken_next;
    logic [HW-1:0]  head_reg, head_next;
    logic [CW-1:0]  count_reg, count_next;

    // Port state memory (head, count) with valid bits for reset-to-zero
    pstate_t        ps_mem [PORTS];
    logic [PORTS-1:0] ps_valid_reg;
    pstate_t        ps_rd_reg;
    logic           ps_rd_vld_reg;
    logic           ps_re;
    logic [PIW-1:0] ps_raddr;
    logic           ps_we;
    logic [PIW-1:0] ps_waddr;
    pstate_t        ps_wdata;
    pstate_t        cur_ps;

    // Destination store, one queue of QUEUE_DEPTH entries per port
    logic [3:0]     q_mem [PORTS * QUEUE_DEPTH];
    logic [3:0]     q_rd_reg;
    logic           q_re;
    logic [SAW-1:0] q_raddr;
    logic           q_we;
    logic [SAW-1:0] q_waddr;
    logic [3:0]     q_wdata;

    logic           rpt;
    logic           go;
    logic           enq_ok;
    logic           granted;
    logic [PIW-1:0] di;
    logic [HW-1:0]  new_head;

    assign cur_ps   = ps_rd_vld_reg ? ps_rd_reg : '0;
    assign rpt      = ({1'b0, port_reg} < RPT_L);
    assign go       = !rpt || res_ready;
    assign enq_ok   = cmd_reg.in_range && (cur_ps.count < D_C);
    assign di       = PIW'(q_rd_reg);
    assign granted  = !taken_reg[di];
    assign new_head = (head_reg == MAX_H) ? '0 : head_reg + 1'b1;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        port_next  = port_reg;
        taken_next = taken_reg;
        head_next  = head_reg;
        count_next = count_reg;
        cmd_ready  = 1'b0;
        res_valid  = 1'b0;
        res        = '0;
        ps_re      = 1'b0;
        ps_raddr   = port_reg;
        ps_we      = 1'b0;
        ps_waddr   = port_reg;
        ps_wdata   = cur_ps;
        q_re       = 1'b0;
        q_raddr    = qbase(port_reg) + SAW'(cur_ps.head);
        q_we       = 1'b0;
        q_waddr    = qbase(port_reg) + SAW'(wrap_add(head_reg, count_reg));
        q_wdata    = q_rd_reg;

        case (state_reg)
            S_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    cmd_next = cmd;
                    if (cmd.op == CMD_ENQUEUE)
                    begin
                        ps_re      = cmd.in_range;
                        ps_raddr   = PIW'(cmd.in_port);
                        state_next = S_ENQ_CHK;
                    end
                    else
                    begin
                        port_next  = '0;
                        taken_next = '0;
                        state_next = S_SLOT_RD;
                    end
                end
            end

            S_ENQ_CHK:
            begin
                res_valid    = 1'b1;
                res.status   = enq_ok ? STAT_ENQUEUED : STAT_DROPPED;
                res.port     = cmd_reg.in_port;
                res.out_port = cmd_reg.dest_port;
                res.last     = 1'b1;
                ps_waddr     = PIW'(cmd_reg.in_port);
                ps_wdata.count = cur_ps.count + 1'b1;
                q_waddr      = qbase(PIW'(cmd_reg.in_port))
                             + SAW'(wrap_add(cur_ps.head, cur_ps.count));
                q_wdata      = cmd_reg.dest_port;
                if (res_ready)
                begin
                    ps_we      = enq_ok;
                    q_we       = enq_ok;
                    state_next = S_IDLE;
                end
            end

            S_SLOT_RD:
            begin
                ps_re      = 1'b1;
                state_next = S_SLOT_CHK;
            end

            S_SLOT_CHK:
            begin
                head_next  = cur_ps.head;
                count_next = cur_ps.count;
                if (cur_ps.count == '0)
                begin
                    res_valid    = rpt;
                    res.status   = STAT_EMPTY;
                    res.port     = 4'(port_reg);
                    res.last     = (port_reg == LAST_P);
                    if (go)
                    begin
                        if (port_reg == MAX_P)
                            state_next = S_IDLE;
                        else
                        begin
                            port_next  = port_reg + 1'b1;
                            state_next = S_SLOT_RD;
                        end
                    end
                end
                else
                begin
                    q_re       = 1'b1;
                    state_next = S_SLOT_EXEC;
                end
            end

            S_SLOT_EXEC:
            begin
                res_valid      = rpt;
                res.status     = granted ? STAT_GRANTED : STAT_BLOCKED;
                res.port       = 4'(port_reg);
                res.out_port   = q_rd_reg;
                res.last       = (port_reg == LAST_P);
                ps_wdata.head  = new_head;
                ps_wdata.count = granted ? count_reg - 1'b1 : count_reg;
                if (go)
                begin
                    ps_we = 1'b1;
                    q_we  = !granted;
                    if (granted)
                        taken_next[di] = 1'b1;
                    if (port_reg == MAX_P)
                        state_next = S_IDLE;
                    else
                    begin
                        port_next  = port_reg + 1'b1;
                        state_next = S_SLOT_RD;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state and port-state valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            port_reg      <= '0;
            taken_reg     <= '0;
            ps_valid_reg  <= '0;
            ps_rd_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            port_reg  <= port_next;
            taken_reg <= taken_next;
            if (ps_re)
                ps_rd_vld_reg <= ps_valid_reg[ps_raddr];
            if (ps_we)
                ps_valid_reg[ps_waddr] <= 1'b1;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        head_reg  <= head_next;
        count_reg <= count_next;
    end

    // Port state memory
    always_ff @(posedge clk)
    begin
        if (ps_we)
            ps_mem[ps_waddr] <= ps_wdata;
        if (ps_re)
            ps_rd_reg <= ps_mem[ps_raddr];
    end

    // Destination store
    always_ff @(posedge clk)
    begin
        if (q_we)
            q_mem[q_waddr] <= q_wdata;
        if (q_re)
            q_rd_reg <= q_mem[q_raddr];
    end

    // A head is only executed for a port that held at least one entry
    a_exec_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SLOT_EXEC) |-> (count_reg != '0))
        else $error("slot execute on an empty queue");

    // Store writes happen only on an enqueue commit or a blocked head
    a_store_write: assert property (@(posedge clk) disable iff (!rst_n)
        q_we |-> (state_reg == S_ENQ_CHK || state_reg == S_SLOT_EXEC))
        else $error("unexpected store write");

    // Queue occupancy never exceeds its depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ps_we |-> (ps_wdata.count <= D_C))
        else $error("queue count overflow");

endmodule

[hdl/iqss_outq.sv]
// Result queue: two-entry buffer between the engine and the result ports,
// so the engine keeps working while a report waits. Depends on iqss_pkg.
module iqss_outq
    import iqss_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  result_t in_res,
    output logic    in_ready,
    output result_t out_res,
    output logic    empty,
    input  logic    pop
);

    result_t head_reg;
    result_t spare_reg;
    logic    head_vld_reg;
    logic    spare_vld_reg;
    logic    wr;
    logic    rd;

    assign in_ready = !spare_vld_reg;
    assign wr       = in_valid && !spare_vld_reg;
    assign rd       = pop && head_vld_reg;
    assign empty    = !head_vld_reg;
    assign out_res  = head_reg;

    // Head is shown on the ports, spare holds the next report
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_vld_reg  <= 1'b0;
            spare_vld_reg <= 1'b0;
        end
        else
        begin
            if (rd)
            begin
                if (spare_vld_reg)
                begin
                    head_reg      <= spare_reg;
                    spare_vld_reg <= 1'b0;
                end
                else if (wr)
                begin
                    head_reg <= in_res;
                end
                else
                begin
                    head_vld_reg <= 1'b0;
                end
            end
            else if (wr)
            begin
                if (!head_vld_reg)
                begin
                    head_reg     <= in_res;
                    head_vld_reg <= 1'b1;
                end
                else
                begin
                    spare_reg     <= in_res;
                    spare_vld_reg <= 1'b1;
                end
            end
        end
    end

    // The spare entry is never occupied ahead of the head entry
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        spare_vld_reg |-> head_vld_reg)
        else $error("result queue order broken");

endmodule

[hdl/input_queued_switch_scheduler.sv]
// Enqueue: the engine reads the port state, then commits and hands the report to the report buffer.
// Slot: the engine takes the command, then visits ports 0..PORTS-1 one at a time: an empty port
// gets a port-state read, a non-empty port a port-state read, store read and update. The engine
// handles one command at a time; the front holds two more, and the engine holds a report while
// the two-entry report buffer is full.
// Reset: asynchronous active low; queues read as empty through per-port valid bits, store undefined.
module input_queued_switch_scheduler
    import iqss_pkg::*;
#(
    parameter int PORTS       = 16,
    parameter int QUEUE_DEPTH = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic       command,
    input  logic [3:0] in_port,
    input  logic [3:0] dest_port,
    output logic       empty,
    input  logic       pop,
    output logic [2:0] status,
    output logic [3:0] port,
    output logic [3:0] out_port,
    output logic       last
);

    logic    cmd_valid;
    cmd_t    cmd;
    logic    cmd_ready;
    logic    res_valid;
    result_t res;
    logic    res_ready;
    result_t out_res;

    // Command intake and classification
    iqss_front #(
        .PORTS (PORTS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .command   (command),
        .in_port   (in_port),
        .dest_port (dest_port),
        .full      (full),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_ready (cmd_ready)
    );

    // Queue and scheduling engine
    iqss_engine #(
        .PORTS       (PORTS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_ready (cmd_ready),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready)
    );

    // Report buffer
    iqss_outq u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (res_valid),
        .in_res   (res),
        .in_ready (res_ready),
        .out_res  (out_res),
        .empty    (empty),
        .pop      (pop)
    );

    assign status   = out_res.status;
    assign port     = out_res.port;
    assign out_port = out_res.out_port;
    assign last     = out_res.last;

endmodule
